// ===== sv/csd_pkg.sv =====
package csd_pkg;

  localparam int unsigned NUM_STREAMS = 64;
  localparam int unsigned STREAM_AW   = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam logic [23:0] TS_ESC      = 24'hffffff;
  localparam logic [23:0] CHUNK_RST   = 24'd128;
  localparam logic [16:0] ID_BASE     = 17'd64;

  // per chunk stream record, kept in one memory word
  typedef struct packed {
    logic [23:0] len;
    logic [23:0] idx;
    logic [7:0]  typ;
    logic [31:0] msid;
    logic [23:0] last;
    logic [31:0] acc;
    logic [31:0] ext;
    logic [31:0] abst;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [16:0] chunk_stream;
    logic        message_end;
    logic [23:0] message_length;
    logic [7:0]  message_type;
    logic [31:0] message_stream;
    logic [31:0] message_time;
    logic        error_code;
  } result_t;

  function automatic logic [3:0] hdr_len(input logic [1:0] fmt);
    logic [3:0] r;
    case (fmt)
      2'd0:    r = 4'd11;
      2'd1:    r = 4'd7;
      2'd2:    r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/csd_byte_if.sv =====
interface csd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== sv/csd_cfg_if.sv =====
interface csd_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] in_chunk_size;
  modport source (output valid, output in_chunk_size, input ready);
  modport sink (input valid, input in_chunk_size, output ready);
endinterface

// ===== sv/csd_res_if.sv =====
interface csd_res_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [16:0] chunk_stream;
  logic        message_end;
  logic [23:0] message_length;
  logic [7:0]  message_type;
  logic [31:0] message_stream;
  logic [31:0] message_time;
  logic        error_code;
  modport source (output valid, output payload_valid, output payload_byte,
                  output chunk_stream, output message_end, output message_length,
                  output message_type, output message_stream, output message_time,
                  output error_code, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input chunk_stream, input message_end, input message_length,
                input message_type, input message_stream, input message_time,
                input error_code, output ready);
endinterface

// ===== sv/csd_ram.sv =====
module csd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/chunk_stream_deframer.sv =====
// Chunk stream deframer: takes one received word per cycle while the output
// queue has room and no record fetch is under way, and returns one result word
// per payload byte, plus one for each empty message and each chunk stream id
// outside the table. Per-stream state sits in a single-port-write, registered-read
// memory; once a basic header has given the stream id, a fetch phase reads that
// stream's record before any further byte of the chunk is taken.
// No clearing pass: per-entry valid bits make untouched streams read as zero.
module chunk_stream_deframer
  import csd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  csd_cfg_if.sink     cfg,
  csd_byte_if.sink    in_ch,
  csd_res_if.source   res
);

  typedef enum logic [2:0] {
    PH_BASIC, PH_ID, PH_MSG, PH_EXT, PH_BODY, PH_FETCH
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [3:0]   hbc_q, hbc_d;
  logic [1:0]   fmt_q, fmt_d;
  logic [16:0]  id_q, id_d;
  logic [23:0]  htime_q, htime_d;
  logic [23:0]  hlen_q, hlen_d;
  logic [7:0]   htype_q, htype_d;
  logic [31:0]  hmsid_q, hmsid_d;
  logic [31:0]  xts_q, xts_d;
  logic [23:0]  cbc_q, cbc_d;
  logic [23:0]  csize_q;
  entry_t       cur_q, cur_d;
  logic [NUM_STREAMS-1:0] vld_q;
  logic         rd_vld_q;

  logic [1:0]   cnt_q;
  result_t      slot_q [2];

  logic         can_go, acc_in, emit, we, re, amh, cmt, pop;
  result_t      rs;
  entry_t       ent, n, rd_ent;
  logic [ENTRY_W-1:0] rd_raw;
  logic [7:0]   b;
  logic [23:0]  ts;
  logic [3:0]   hnext;
  logic [24:0]  idx_inc;

  assign can_go      = (cnt_q != 2'd2);
  assign in_ch.ready = can_go && (phase_q != PH_FETCH);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign cfg.ready   = 1'b1;
  assign b           = in_ch.data_byte;
  assign hnext       = hbc_q + 4'd1;

  csd_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_STREAMS), .AW(STREAM_AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (id_q[STREAM_AW-1:0]),
    .wdata_i (cur_d),
    .re_i    (re),
    .raddr_i (id_d[STREAM_AW-1:0]),
    .rdata_o (rd_raw)
  );

  assign rd_ent = rd_vld_q ? entry_t'(rd_raw) : '0;
  assign ent    = (phase_q == PH_FETCH) ? rd_ent : cur_q;

  always_comb begin
    phase_d = phase_q;
    hbc_d   = hbc_q;
    fmt_d   = fmt_q;
    id_d    = id_q;
    htime_d = htime_q;
    hlen_d  = hlen_q;
    htype_d = htype_q;
    hmsid_d = hmsid_q;
    xts_d   = xts_q;
    cbc_d   = cbc_q;
    cur_d   = cur_q;
    emit    = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    amh     = 1'b0;
    cmt     = 1'b0;
    rs      = '0;
    n       = ent;
    ts      = '0;
    idx_inc = '0;
    case (phase_q)
      PH_BASIC: begin
        if (acc_in) begin
          fmt_d   = b[7:6];
          htime_d = '0;
          hlen_d  = '0;
          htype_d = '0;
          hmsid_d = '0;
          xts_d   = '0;
          if (b[5:0] <= 6'd1) begin
            id_d    = ID_BASE;
            hbc_d   = (b[5:0] == 6'd0) ? 4'd1 : 4'd2;
            phase_d = PH_ID;
          end else begin
            id_d    = {11'd0, b[5:0]};
            phase_d = PH_FETCH;
            re      = (id_d < 17'(NUM_STREAMS));
          end
        end
      end
      PH_ID: begin
        if (acc_in) begin
          if (hbc_q == 4'd2) begin
            id_d  = id_q + {9'd0, b};
            hbc_d = 4'd3;
          end else begin
            id_d    = (hbc_q == 4'd3) ? id_q + {1'b0, b, 8'd0} : id_q + {9'd0, b};
            phase_d = PH_FETCH;
            re      = (id_d < 17'(NUM_STREAMS));
          end
        end
      end
      PH_FETCH: begin
        if (can_go) begin
          if (id_q >= 17'(NUM_STREAMS)) begin
            emit            = 1'b1;
            rs.chunk_stream = id_q;
            rs.error_code   = 1'b1;
            phase_d         = PH_BASIC;
          end else begin
            cur_d = rd_ent;
            if (hdr_len(fmt_q) == 4'd0) begin
              amh = 1'b1;
            end else begin
              phase_d = PH_MSG;
              hbc_d   = '0;
            end
          end
        end
      end
      PH_MSG: begin
        if (acc_in) begin
          if (hbc_q < 4'd3) begin
            htime_d = {htime_q[15:0], b};
          end else if (hbc_q < 4'd6) begin
            hlen_d = {hlen_q[15:0], b};
          end else if (hbc_q == 4'd6) begin
            htype_d = b;
          end else if (hbc_q < 4'd11) begin
            // stream id is little endian
            hmsid_d = {b, hmsid_q[31:8]};
          end
          hbc_d = hnext;
          if (hnext >= hdr_len(fmt_q)) begin
            amh = 1'b1;
          end
        end
      end
      PH_EXT: begin
        if (acc_in) begin
          xts_d = {xts_q[23:0], b};
          hbc_d = hnext;
          if (hnext >= 4'd4) begin
            cmt = 1'b1;
          end
        end
      end
      PH_BODY: begin
        if (acc_in) begin
          idx_inc = {1'b0, ent.idx} + 25'd1;
          n.idx   = idx_inc[23:0];
          cbc_d   = cbc_q + 24'd1;
          emit    = 1'b1;
          we      = 1'b1;
          rs.payload_valid = 1'b1;
          rs.payload_byte  = b;
          if (idx_inc >= {1'b0, ent.len}) begin
            n.abst  = ent.abst + ((ent.acc >= {8'd0, TS_ESC}) ? ent.ext : ent.acc);
            n.idx   = '0;
            n.acc   = '0;
            n.ext   = '0;
            rs.message_end  = 1'b1;
            rs.message_time = n.abst;
            phase_d = PH_BASIC;
          end else if (cbc_d >= csize_q) begin
            phase_d = PH_BASIC;
          end
          cur_d = n;
        end
      end
      default: phase_d = PH_BASIC;
    endcase

    if (amh) begin
      ts = (fmt_q == 2'd3) ? ent.last : htime_d;
      if (ts >= TS_ESC || ent.acc >= {8'd0, TS_ESC}) begin
        phase_d = PH_EXT;
        hbc_d   = '0;
      end else begin
        cmt = 1'b1;
      end
    end

    if (cmt) begin
      n  = ent;
      ts = htime_d;
      if (fmt_q <= 2'd1) begin
        n.len = hlen_d;
        n.idx = '0;
        n.typ = htype_d;
        if (fmt_q == 2'd0) begin
          n.msid = hmsid_d;
        end
      end
      if (fmt_q == 2'd1 || fmt_q == 2'd2) begin
        n.last = ts;
      end else if (fmt_q == 2'd3) begin
        ts = ent.last;
      end
      if (n.idx == '0) begin
        if (fmt_q == 2'd0) begin
          n.abst = '0;
          n.acc  = {8'd0, ts};
          n.ext  = xts_d;
        end else if (n.acc >= {8'd0, TS_ESC}) begin
          n.ext = n.ext + xts_d;
        end else begin
          n.acc = n.acc + {8'd0, ts};
          if (ts >= TS_ESC) begin
            n.ext = n.ext + xts_d;
          end
        end
      end
      phase_d = PH_BODY;
      cbc_d   = '0;
      we      = 1'b1;
      if (n.idx >= n.len) begin
        // empty message closes right at the header
        n.abst  = n.abst + ((n.acc >= {8'd0, TS_ESC}) ? n.ext : n.acc);
        n.idx   = '0;
        n.acc   = '0;
        n.ext   = '0;
        phase_d = PH_BASIC;
        emit    = 1'b1;
        rs.message_end  = 1'b1;
        rs.message_time = n.abst;
      end
      cur_d = n;
    end

    if (emit && !rs.error_code) begin
      rs.chunk_stream   = id_q;
      rs.message_length = cur_d.len;
      rs.message_type   = cur_d.typ;
      rs.message_stream = cur_d.msid;
    end else if (emit) begin
      rs.chunk_stream = id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BASIC;
      hbc_q    <= '0;
      fmt_q    <= '0;
      id_q     <= '0;
      htime_q  <= '0;
      hlen_q   <= '0;
      htype_q  <= '0;
      hmsid_q  <= '0;
      xts_q    <= '0;
      cbc_q    <= '0;
      csize_q  <= CHUNK_RST;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hbc_q   <= hbc_d;
      fmt_q   <= fmt_d;
      id_q    <= id_d;
      htime_q <= htime_d;
      hlen_q  <= hlen_d;
      htype_q <= htype_d;
      hmsid_q <= hmsid_d;
      xts_q   <= xts_d;
      cbc_q   <= cbc_d;
      if (cfg.valid && cfg.ready) begin
        csize_q <= cfg.in_chunk_size;
      end
      if (we) begin
        vld_q[id_q[STREAM_AW-1:0]] <= 1'b1;
      end
      if (re) begin
        rd_vld_q <= vld_q[id_d[STREAM_AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // two-word output queue
  assign pop       = res.valid && res.ready;
  assign res.valid = (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + {1'b0, emit} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
      slot_q[0] <= rs;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
    end
    if (emit && !(cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
      slot_q[1] <= rs;
    end
  end

  assign res.payload_valid  = slot_q[0].payload_valid;
  assign res.payload_byte   = slot_q[0].payload_byte;
  assign res.chunk_stream   = slot_q[0].chunk_stream;
  assign res.message_end    = slot_q[0].message_end;
  assign res.message_length = slot_q[0].message_length;
  assign res.message_type   = slot_q[0].message_type;
  assign res.message_stream = slot_q[0].message_stream;
  assign res.message_time   = slot_q[0].message_time;
  assign res.error_code     = slot_q[0].error_code;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output queue overflow");

  a_fetch_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FETCH) |-> !in_ch.ready) else $error("byte taken during fetch");

  a_no_write_basic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BASIC || phase_q == PH_ID) |-> !we) else $error("table write in header");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && rs.error_code) |-> (!rs.payload_valid && !rs.message_end))
    else $error("error word carries payload");

endmodule

// ===== tb/sv/chunk_stream_deframer_tb.sv =====
`timescale 1ns / 1ps

module chunk_stream_deframer_tb;
  import csd_pkg::*;

  typedef enum logic [2:0] {
    PH_BASIC, PH_ID, PH_MSG, PH_EXT, PH_BODY
  } parse_phase_e;

  localparam int unsigned MSG_HDR_BYTES [4] = '{11, 7, 3, 0};
  localparam logic [31:0] ACC_ESC = {8'h00, TS_ESC};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  csd_cfg_if  cfg_if ();
  csd_byte_if in_if ();
  csd_res_if  res_if ();

  chunk_stream_deframer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_if),
    .in_ch  (in_if),
    .res    (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // deframer mirror: header registers and per-stream tables
  logic [23:0]  chunk_size;
  parse_phase_e phase;
  logic [3:0]   hdr_cnt;
  logic [1:0]   fmt;
  logic [16:0]  cur_id;
  logic [23:0]  hdr_time, hdr_len;
  logic [39:0]  hdr_type_msid;
  logic [31:0]  hdr_ext;
  logic [23:0]  chunk_cnt;
  logic [23:0]  s_len [NUM_STREAMS];
  logic [23:0]  s_idx [NUM_STREAMS];
  logic [7:0]   s_type [NUM_STREAMS];
  logic [31:0]  s_msid [NUM_STREAMS];
  logic [23:0]  s_last [NUM_STREAMS];
  logic [31:0]  s_acc [NUM_STREAMS];
  logic [31:0]  s_ext [NUM_STREAMS];
  logic [31:0]  s_abs [NUM_STREAMS];

  result_t expected_words [$];
  bit      no_idle = 1'b0;
  int      n_fail = 0, n_bytes = 0, n_words = 0, n_msgs = 0, n_errs = 0;
  int      last_id = 2;
  bit      want_esc = 1'b0;

  function automatic void mirror_reset();
    chunk_size = CHUNK_RST;
    phase = PH_BASIC;
    hdr_cnt = '0; fmt = '0; cur_id = '0;
    hdr_time = '0; hdr_len = '0; hdr_type_msid = '0; hdr_ext = '0; chunk_cnt = '0;
    for (int i = 0; i < NUM_STREAMS; i++) begin
      s_len[i] = '0; s_idx[i] = '0; s_type[i] = '0; s_msid[i] = '0;
      s_last[i] = '0; s_acc[i] = '0; s_ext[i] = '0; s_abs[i] = '0;
    end
  endfunction

  function automatic void queue_word(logic pv, logic [7:0] b, logic mend, logic [31:0] t,
                                     logic err);
    result_t r;
    r = '0;
    r.payload_valid = pv;
    r.payload_byte = b;
    r.chunk_stream = cur_id;
    r.message_end = mend;
    r.error_code = err;
    if (!err && cur_id < NUM_STREAMS) begin
      r.message_length = s_len[cur_id];
      r.message_type = s_type[cur_id];
      r.message_stream = s_msid[cur_id];
      r.message_time = t;
    end
    expected_words.push_back(r);
  endfunction

  function automatic logic [31:0] close_message(int s);
    s_abs[s] += (s_acc[s] >= ACC_ESC) ? s_ext[s] : s_acc[s];
    s_idx[s] = '0;
    s_acc[s] = '0;
    s_ext[s] = '0;
    return s_abs[s];
  endfunction

  function automatic void apply_header();
    int s;
    logic [23:0] len, idx, last, ts;
    logic [31:0] acc;
    s = cur_id;
    len = s_len[s]; idx = s_idx[s]; last = s_last[s]; acc = s_acc[s];
    ts = hdr_time;
    if (fmt <= 2'd1) begin
      len = hdr_len;
      idx = '0;
      s_type[s] = hdr_type_msid[39:32];
      if (fmt == 2'd0) s_msid[s] = hdr_type_msid[31:0];
    end
    if (fmt == 2'd1 || fmt == 2'd2) last = ts;
    else if (fmt == 2'd3) ts = last;
    if (idx == 0) begin
      if (fmt == 2'd0) begin
        s_abs[s] = '0;
        acc = {8'h00, ts};
        s_ext[s] = hdr_ext;
      end else if (acc >= ACC_ESC) begin
        s_ext[s] += hdr_ext;
      end else begin
        acc += {8'h00, ts};
        if (ts >= TS_ESC) s_ext[s] += hdr_ext;
      end
    end
    s_len[s] = len; s_idx[s] = idx; s_last[s] = last; s_acc[s] = acc;
    phase = PH_BODY;
    chunk_cnt = '0;
    if (idx >= len) begin
      phase = PH_BASIC;
      queue_word(1'b0, 8'h00, 1'b1, close_message(s), 1'b0);
    end
  endfunction

  function automatic void header_done();
    logic [23:0] ts;
    ts = (fmt == 2'd3) ? s_last[cur_id] : hdr_time;
    if (ts >= TS_ESC || s_acc[cur_id] >= ACC_ESC) begin
      phase = PH_EXT;
      hdr_cnt = '0;
    end else begin
      apply_header();
    end
  endfunction

  function automatic void id_done();
    if (cur_id >= NUM_STREAMS) begin
      phase = PH_BASIC;
      queue_word(1'b0, 8'h00, 1'b0, '0, 1'b1);
    end else if (MSG_HDR_BYTES[fmt] == 0) begin
      header_done();
    end else begin
      phase = PH_MSG;
      hdr_cnt = '0;
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    int n;
    case (phase)
      PH_BASIC: begin
        fmt = b[7:6];
        hdr_time = '0; hdr_len = '0; hdr_type_msid = '0; hdr_ext = '0;
        if (b[5:0] <= 6'd1) begin
          cur_id = ID_BASE;
          hdr_cnt = (b[5:0] == 6'd0) ? 4'd1 : 4'd2;
          phase = PH_ID;
        end else begin
          cur_id = {11'd0, b[5:0]};
          id_done();
        end
      end
      PH_ID: begin
        if (hdr_cnt == 4'd2) begin
          cur_id += {9'd0, b};
          hdr_cnt = 4'd3;
        end else begin
          cur_id += (hdr_cnt == 4'd3) ? {1'b0, b, 8'h00} : {9'd0, b};
          id_done();
        end
      end
      PH_MSG: begin
        n = hdr_cnt;
        if (n < 3) hdr_time = {hdr_time[15:0], b};
        else if (n < 6) hdr_len = {hdr_len[15:0], b};
        else if (n == 6) hdr_type_msid = {b, 32'h0};
        else if (n < 11) hdr_type_msid |= {32'h0, b} << (8 * (n - 7));
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= MSG_HDR_BYTES[fmt]) header_done();
      end
      PH_EXT: begin
        hdr_ext = {hdr_ext[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= 4'd4) apply_header();
      end
      default: begin
        s_idx[cur_id] = s_idx[cur_id] + 24'd1;
        chunk_cnt = chunk_cnt + 24'd1;
        if (s_idx[cur_id] >= s_len[cur_id]) begin
          phase = PH_BASIC;
          queue_word(1'b1, b, 1'b1, close_message(cur_id), 1'b0);
        end else begin
          if (chunk_cnt >= chunk_size) phase = PH_BASIC;
          queue_word(1'b1, b, 1'b0, '0, 1'b0);
        end
      end
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b);
    if (!no_idle && $urandom_range(0, 99) < 35) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    deframe_byte(b);
    n_bytes++;
  endtask

  task automatic send_list(logic [7:0] q [$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // block idle: drain results, let trailing header bytes settle, then write
  task automatic set_chunk_size(logic [23:0] v);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.in_chunk_size <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    chunk_size = v;
  endtask

  always @(posedge clk_i) begin
    res_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 26);
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word, stream %0h", res_if.chunk_stream);
        n_fail++;
      end else begin
        e = expected_words.pop_front();
        check_field("payload_valid", e.payload_valid, res_if.payload_valid);
        check_field("payload_byte", e.payload_byte, res_if.payload_byte);
        check_field("chunk_stream", e.chunk_stream, res_if.chunk_stream);
        check_field("message_end", e.message_end, res_if.message_end);
        check_field("message_length", e.message_length, res_if.message_length);
        check_field("message_type", e.message_type, res_if.message_type);
        check_field("message_stream", e.message_stream, res_if.message_stream);
        check_field("message_time", e.message_time, res_if.message_time);
        check_field("error_code", e.error_code, res_if.error_code);
        n_words++;
        if (e.message_end) n_msgs++;
        if (e.error_code) n_errs++;
      end
    end
  end

  // one-byte id forms, empty message, ids past the table in two- and three-byte form
  task automatic test_header_forms();
    send_list('{8'h02, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h03, 8'h08,
                8'h01, 8'h02, 8'h03, 8'h04, 8'hAA, 8'h55, 8'hFF});
    send_list('{8'h3F, 8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_list('{8'h00, 8'h05, 8'hC1, 8'hFF, 8'hFF});
  endtask

  // extended timestamp, then format 1, 2 and 3 deltas on the same stream
  task automatic test_formats_and_ext();
    send_list('{8'h03, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h02, 8'h09,
                8'h11, 8'h22, 8'h33, 8'h44, 8'h12, 8'h34, 8'h56, 8'h78, 8'h01, 8'h02});
    send_list('{8'h43, 8'h00, 8'h00, 8'h0A, 8'h00, 8'h00, 8'h01, 8'h14, 8'h5A});
    send_list('{8'h83, 8'h00, 8'h00, 8'h14, 8'hA5, 8'hC3, 8'h3C});
    send_list('{8'h44, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h12,
                8'h00, 8'h00, 8'h00, 8'h10, 8'h77});
  endtask

  // one-byte chunks with format 3 continuations, and a format 0 restart mid message
  task automatic test_chunking();
    set_chunk_size(24'd1);
    send_list('{8'h04, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h03, 8'h01,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'hC4, 8'h20, 8'hC4, 8'h30});
    send_list('{8'h05, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h04, 8'h07,
                8'h09, 8'h00, 8'h00, 8'h00, 8'hEE});
    send_list('{8'h05, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h01, 8'h07,
                8'h09, 8'h00, 8'h00, 8'h00, 8'hDD});
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    int s;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 3 && !(phase == PH_MSG && hdr_cnt inside {3, 4})) return b;
    case (phase)
      PH_BASIC: begin
        want_esc = ($urandom_range(0, 99) < 12);
        if ($urandom_range(0, 99) < 6)
          return {b[7:6], 5'd0, b[0]};
        s = last_id;
        if (s_idx[s] != 0 && s_idx[s] < s_len[s] && $urandom_range(0, 99) < 75) begin
          b[7:6] = ($urandom_range(0, 9) == 0) ? 2'd1 : 2'd3;
        end else begin
          s = $urandom_range(2, 7);
          b[7:6] = ($urandom_range(0, 99) < 40) ? 2'd0 : 2'($urandom_range(1, 3));
        end
        last_id = s;
        return {b[7:6], 6'(s)};
      end
      PH_MSG: begin
        if (hdr_cnt < 3) return want_esc ? 8'hFF : b;
        if (hdr_cnt < 5) return 8'h00;
        if (hdr_cnt == 5) return ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 48));
        return b;
      end
      PH_EXT: return ($urandom_range(0, 9) == 0) ? 8'hFF : b;
      default: return b;
    endcase
  endfunction

  task automatic test_random_stream(int n, logic [23:0] csize);
    set_chunk_size(csize);
    for (int i = 0; i < n; i++) send_byte(pick_byte());
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.in_chunk_size = '0;
    res_if.ready = 1'b0;
    mirror_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_forms();
    test_formats_and_ext();
    test_chunking();
    test_random_stream(270, 24'hFFFFFF);
    test_random_stream(270, 24'($urandom_range(1, 40)));
    no_idle = 1'b1;
    test_random_stream(270, 24'd1);
    no_idle = 1'b0;
    test_random_stream(270, 24'($urandom_range(2, 16)));
    test_random_stream(270, CHUNK_RST);
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d input words, %0d result words checked", n_bytes, n_words);
    $display("%0d messages ended, %0d out-of-table stream ids", n_msgs, n_errs);
    if (n_fail == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout, %0d result words still pending", expected_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
